[src/pla_pkg.sv]
// Shared types, constants and register codes for the pixel levels adjustment block.
package pla_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PIX_W           = 16;
    localparam int LVL_W           = PIX_W + 1;
    localparam int PCT_W           = 10;
    localparam int SEL_W           = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int NUM_LANES       = 3;

    // Percentage times level, and the reciprocal of one thousand used to scale it down.
    localparam int PROD_W    = PCT_W + PIX_W;
    localparam int DIV_SHIFT = PROD_W + 10;
    localparam int RECIP_W   = 27;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000);

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_SEL  = 3'd4;

    localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
    localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd2;
    localparam logic [SEL_W-1:0] SEL_ALL   = 2'd3;

    localparam logic [PIX_W-1:0] MAX_LEVEL_RST = 16'd255;
    localparam logic [PCT_W-1:0] BLACK_RST     = 10'd0;
    localparam logic [PCT_W-1:0] WHITE_RST     = 10'd1000;
    localparam logic             COLOR_RST     = 1'b0;
    localparam logic [SEL_W-1:0] SEL_RST       = SEL_ALL;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [LVL_W-1:0] lo;
        logic [LVL_W-1:0] hi;
        logic [LVL_W-1:0] den;
        logic             color;
        logic [SEL_W-1:0] sel;
    } pla_cfg_t;

endpackage

[src/pla_if.sv]
// Valid/ready stream interfaces for input pixels and adjusted pixels.
interface pla_in_if;
    import pla_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_or_gray;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output red_or_gray, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_or_gray, input green_in, input blue_in,
                    output ready);
endinterface

interface pla_out_if;
    import pla_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_or_gray_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, output red_or_gray_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_or_gray_out, input green_out, input blue_out,
                    output ready);
endinterface

[src/pla_cfg.sv]
// Configuration registers and the sequencer that derives the black and white levels.
module pla_cfg #(
    parameter int SAMPLE_BITS = pla_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pla_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pla_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pla_pkg::pla_cfg_t                cfg,
    output logic                             busy
);
    import pla_pkg::*;

    localparam logic [PIX_W-1:0] SAMPLE_MAX = PIX_W'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam int SCALE_W = PROD_W + RECIP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;
    localparam logic [1:0] ST_DIFF  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PIX_W-1:0]  max_level_reg, max_level_next;
    logic [PCT_W-1:0]  black_reg, black_next;
    logic [PCT_W-1:0]  white_reg, white_next;
    logic              color_reg, color_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;
    logic [PIX_W-1:0]  top_reg, top_next;
    logic [LVL_W-1:0]  lo_reg, lo_next;
    logic [LVL_W-1:0]  hi_reg, hi_next;
    logic [LVL_W-1:0]  den_reg, den_next;
    logic [PROD_W-1:0] prod_b_reg, prod_w_reg;
    logic [PIX_W-1:0]  top_eff;
    logic [SCALE_W-1:0] scaled_b, scaled_w;

    assign top_eff  = (max_level_reg > SAMPLE_MAX) ? SAMPLE_MAX : max_level_reg;
    // Multiplying by the reciprocal gives the exact floor of a division by one thousand.
    assign scaled_b = SCALE_W'(prod_b_reg) * SCALE_W'(DIV_RECIP);
    assign scaled_w = SCALE_W'(prod_w_reg) * SCALE_W'(DIV_RECIP);

    always_comb
    begin
        max_level_next = max_level_reg;
        black_next     = black_reg;
        white_next     = white_reg;
        color_next     = color_reg;
        sel_next       = sel_reg;
        top_next       = top_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        den_next       = den_reg;
        state_next     = state_reg;

        case (state_reg)
            ST_MUL:
            begin
                top_next   = top_eff;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                lo_next    = scaled_b[DIV_SHIFT +: LVL_W];
                hi_next    = scaled_w[DIV_SHIFT +: LVL_W];
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                den_next   = hi_reg - lo_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            // Any write restarts the derivation from the new register values.
            state_next = ST_MUL;
            case (cfg_index)
                REG_MAX_LEVEL: max_level_next = cfg_data[PIX_W-1:0];
                REG_BLACK:     black_next     = cfg_data[PCT_W-1:0];
                REG_WHITE:     white_next     = cfg_data[PCT_W-1:0];
                REG_COLOR:     color_next     = cfg_data[0];
                REG_CHAN_SEL:  sel_next       = cfg_data[SEL_W-1:0];
                default:       ;
            endcase
        end
    end

    // The derived levels reset to what the register reset values produce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_level_reg <= MAX_LEVEL_RST;
            black_reg     <= BLACK_RST;
            white_reg     <= WHITE_RST;
            color_reg     <= COLOR_RST;
            sel_reg       <= SEL_RST;
            top_reg       <= MAX_LEVEL_RST;
            lo_reg        <= '0;
            hi_reg        <= LVL_W'(MAX_LEVEL_RST);
            den_reg       <= LVL_W'(MAX_LEVEL_RST);
        end
        else
        begin
            state_reg     <= state_next;
            max_level_reg <= max_level_next;
            black_reg     <= black_next;
            white_reg     <= white_next;
            color_reg     <= color_next;
            sel_reg       <= sel_next;
            top_reg       <= top_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            den_reg       <= den_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_b_reg <= PROD_W'(black_reg) * PROD_W'(top_eff);
            prod_w_reg <= PROD_W'(white_reg) * PROD_W'(top_eff);
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign cfg  = '{top: top_reg, lo: lo_reg, hi: hi_reg, den: den_reg,
                    color: color_reg, sel: sel_reg};

endmodule

[src/pla_lane.sv]
// One channel lane: classification, scaling multiply and a pipelined restoring divider.
module pla_lane #(
    parameter int SAMPLE_BITS = pla_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic [SAMPLE_BITS+2:0] advance,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  pla_pkg::pla_cfg_t      cfg,
    input  logic                   adjust_en,
    output logic [SAMPLE_BITS-1:0] result
);
    import pla_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int DIV0 = 3;

    logic [S-1:0]   samp_a_reg;
    logic [S-1:0]   raw_b_reg, diff_b_reg;
    logic           le_b_reg, ge_b_reg;
    logic [S-1:0]   raw_c_reg;
    logic [2*S-1:0] num_c_reg;
    logic           le_c_reg, ge_c_reg;

    logic [S:0]     rem_reg [S];
    logic [S-1:0]   low_reg [S];
    logic [S-1:0]   quo_reg [S];
    logic [S-1:0]   raw_reg [S];
    logic           le_reg  [S];
    logic           ge_reg  [S];

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            samp_a_reg <= sample;
        end
        if (advance[1])
        begin
            raw_b_reg  <= samp_a_reg;
            le_b_reg   <= ({1'b0, samp_a_reg} <= cfg.lo[S:0]);
            ge_b_reg   <= ({1'b0, samp_a_reg} >= cfg.hi[S:0]);
            diff_b_reg <= samp_a_reg - cfg.lo[S-1:0];
        end
        if (advance[2])
        begin
            raw_c_reg <= raw_b_reg;
            le_c_reg  <= le_b_reg;
            ge_c_reg  <= ge_b_reg;
            num_c_reg <= (2*S)'(diff_b_reg) * (2*S)'(cfg.top[S-1:0]);
        end
    end

    // The quotient stays below the level maximum, so the upper half of the
    // numerator is already smaller than the divisor and one bit per stage suffices.
    for (genvar j = 0; j < S; j++)
    begin : g_div
        logic [S:0]   rem_in;
        logic [S-1:0] low_in;
        logic [S-1:0] quo_in;
        logic [S-1:0] raw_in;
        logic         le_in;
        logic         ge_in;
        logic [S+1:0] trial;
        logic [S+1:0] rem_sub;
        logic         fits;

        if (j == 0)
        begin : g_first
            assign rem_in = {1'b0, num_c_reg[2*S-1:S]};
            assign low_in = num_c_reg[S-1:0];
            assign quo_in = '0;
            assign raw_in = raw_c_reg;
            assign le_in  = le_c_reg;
            assign ge_in  = ge_c_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign low_in = low_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign raw_in = raw_reg[j-1];
            assign le_in  = le_reg[j-1];
            assign ge_in  = ge_reg[j-1];
        end

        assign trial   = {rem_in, low_in[S-1]};
        assign rem_sub = trial - {1'b0, cfg.den[S:0]};
        assign fits    = (trial >= {1'b0, cfg.den[S:0]});

        always_ff @(posedge clk)
        begin
            if (advance[DIV0+j])
            begin
                rem_reg[j] <= fits ? rem_sub[S:0] : trial[S:0];
                low_reg[j] <= low_in << 1;
                quo_reg[j] <= {quo_in[S-2:0], fits};
                raw_reg[j] <= raw_in;
                le_reg[j]  <= le_in;
                ge_reg[j]  <= ge_in;
            end
        end
    end

    always_comb
    begin
        if (!adjust_en)
        begin
            result = raw_reg[S-1];
        end
        else if (le_reg[S-1])
        begin
            result = '0;
        end
        else if (ge_reg[S-1])
        begin
            result = cfg.top[S-1:0];
        end
        else
        begin
            result = quo_reg[S-1];
        end
    end

endmodule

[src/pla_merge.sv]
// Output stage that gathers the three lane results into one adjusted pixel.
module pla_merge #(
    parameter int SAMPLE_BITS = pla_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     load,
    input  logic                     color,
    input  logic [SAMPLE_BITS-1:0]   lane_res [pla_pkg::NUM_LANES],
    output logic [pla_pkg::PIX_W-1:0] red_or_gray_out,
    output logic [pla_pkg::PIX_W-1:0] green_out,
    output logic [pla_pkg::PIX_W-1:0] blue_out
);
    import pla_pkg::*;

    logic [PIX_W-1:0] red_reg, green_reg, blue_reg;

    // A gray pixel carries nothing in the green and blue fields.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= PIX_W'(lane_res[0]);
            green_reg <= color ? PIX_W'(lane_res[1]) : '0;
            blue_reg  <= color ? PIX_W'(lane_res[2]) : '0;
        end
    end

    assign red_or_gray_out = red_reg;
    assign green_out       = green_reg;
    assign blue_out        = blue_reg;

endmodule

[src/pixel_levels_adjust.sv]
// Throughput: one pixel per cycle unless the output stalls or a configuration write holds
// off requests; each lane's divider retires one quotient bit per stage. A configuration
// write holds off requests in its own cycle and while the levels are then rederived
// through the percentage multiply and the scale by 1/1000.
// Reset clears all stage valid flags and loads the register defaults; there is no
// clearing pass.
module pixel_levels_adjust #(
    parameter int SAMPLE_BITS = pla_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pla_pkg::CFG_DATA_W-1:0] cfg_data,
    pla_in_if.sink                         pixel_in,
    pla_out_if.source                      pixel_out
);
    import pla_pkg::*;

    localparam int S   = SAMPLE_BITS;
    localparam int NST = S + 4;

    pla_cfg_t         cfg;
    logic             cfg_busy;
    logic [NST-1:0]   valid_reg, valid_next, advance;
    logic             in_accept;
    logic [S-1:0]     lane_in  [NUM_LANES];
    logic [S-1:0]     lane_res [NUM_LANES];
    logic [NUM_LANES-1:0] lane_en;

    pla_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (cfg_busy)
    );

    // A stage moves on when the output is taken or a bubble lies at that stage or anywhere after it.
    for (genvar k = 0; k < NST; k++)
    begin : g_adv
        assign advance[k] = pixel_out.ready || !(&valid_reg[NST-1:k]);
    end

    assign pixel_in.ready = advance[0] && !cfg_busy && !cfg_we;
    assign in_accept      = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        valid_next[0] = advance[0] ? in_accept : valid_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            valid_next[k] = advance[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        lane_en[0] = !cfg.color || (cfg.sel inside {SEL_RED, SEL_ALL});
        lane_en[1] = cfg.color && (cfg.sel inside {SEL_GREEN, SEL_ALL});
        lane_en[2] = cfg.color && (cfg.sel inside {SEL_BLUE, SEL_ALL});
    end

    assign lane_in[0] = pixel_in.red_or_gray[S-1:0];
    assign lane_in[1] = pixel_in.green_in[S-1:0];
    assign lane_in[2] = pixel_in.blue_in[S-1:0];

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        pla_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
            .clk       (clk),
            .advance   (advance[S+2:0]),
            .sample    (lane_in[i]),
            .cfg       (cfg),
            .adjust_en (lane_en[i]),
            .result    (lane_res[i])
        );
    end

    pla_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .clk             (clk),
        .load            (advance[NST-1]),
        .color           (cfg.color),
        .lane_res        (lane_res),
        .red_or_gray_out (pixel_out.red_or_gray_out),
        .green_out       (pixel_out.green_out),
        .blue_out        (pixel_out.blue_out)
    );

    assign pixel_out.valid = valid_reg[NST-1];

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> cfg_busy)
        else $error("level derivation did not start after a configuration write");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !pixel_out.ready) |-> !pixel_in.ready)
        else $error("request taken while every stage is full and the output is stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_out.valid && pixel_out.ready && !valid_reg[NST-2]) |=> !pixel_out.valid)
        else $error("result repeated after it was taken");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> valid_reg[0])
        else $error("accepted request did not enter the first stage");

endmodule
